// ----- hdl/nesm_pkg.sv -----
package nesm_pkg;

  localparam int PENDING_DEPTH = 16;
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

  localparam logic [2:0] KIND_OFF  = 3'd0;
  localparam logic [2:0] KIND_CHAN = 3'd1;
  localparam logic [2:0] KIND_LOOP = 3'd2;
  localparam logic [2:0] KIND_END  = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TRUNC = 2'd1;
  localparam logic [1:0] ERR_LEAD  = 2'd2;
  localparam logic [1:0] ERR_FULL  = 2'd3;

  localparam logic [27:0] DELAY_MAX = 28'hFFFFFFF;

  typedef struct packed {
    logic [3:0]  chan;
    logic [6:0]  note;
    logic [31:0] t;
  } pend_t;

  // shift command to the cell row
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    pend_t       ins;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_EMIT,
    ST_ERR,
    ST_DRAIN,
    ST_END
  } state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFFFFFF : s[31:0];
  endfunction

  function automatic logic [31:0] vlq(input logic [27:0] d);
    logic [31:0] c;
    c = {24'd0, 1'b0, d[6:0]};
    if (d[27:7] != 0) c[15:8] = {1'b1, d[13:7]};
    if (d[27:14] != 0) c[23:16] = {1'b1, d[20:14]};
    if (d[27:21] != 0) c[31:24] = {1'b1, d[27:21]};
    return c;
  endfunction

  function automatic logic [2:0] vlq_len(input logic [27:0] d);
    if (d[27:21] != 0) return 3'd4;
    if (d[20:14] != 0) return 3'd3;
    if (d[13:7] != 0) return 3'd2;
    return 3'd1;
  endfunction

endpackage

// ----- hdl/nesm_cell.sv -----
module nesm_cell
  import nesm_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      valid,
  input  logic      prev_valid,
  input  logic      prev_le,
  input  pend_t     prev_entry,
  input  pend_t     next_entry,
  output pend_t     entry,
  output logic      le
);
  // le: this entry's time is at or below the insert time
  assign le = valid && (entry.t <= ctl.ins.t);

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CMD_INSERT: begin
        if (!le) begin
          if (prev_valid && !prev_le) entry <= prev_entry;
          else entry <= ctl.ins;
        end
      end
      CMD_POP: entry <= next_entry;
      default: entry <= entry;
    endcase
  end
endmodule

// ----- hdl/nesm_store.sv -----
module nesm_store
  import nesm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  output pend_t            head,
  output logic [CNT_W-1:0] count
);
  pend_t entries [PENDING_DEPTH];
  logic  les [PENDING_DEPTH];
  logic  vld [PENDING_DEPTH];

  for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_cell
    pend_t pe, ne;
    logic  pv, pl;
    assign vld[i] = CNT_W'(i) < count;
    if (i == 0) begin : g_first
      assign pe = ctl.ins;
      assign pv = 1'b0;
      assign pl = 1'b1;
    end else begin : g_rest
      assign pe = entries[i-1];
      assign pv = vld[i-1];
      assign pl = les[i-1];
    end
    if (i == PENDING_DEPTH - 1) begin : g_last
      assign ne = entries[i];
    end else begin : g_mid
      assign ne = entries[i+1];
    end
    nesm_cell u_cell (
      .clk(clk), .ctl(ctl), .valid(vld[i]), .prev_valid(pv), .prev_le(pl),
      .prev_entry(pe), .next_entry(ne), .entry(entries[i]), .le(les[i])
    );
  end

  assign head = entries[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (ctl.cmd)
        CMD_INSERT: count <= count + 1'b1;
        CMD_POP:    count <= count - 1'b1;
        default:    count <= count;
      endcase
    end
  end
endmodule

// ----- hdl/note_event_stream_to_midi.sv -----
// An accepted word is registered and handled in ST_FLUSH; stall_in holds the input until the block is back in
// ST_IDLE, so a new input word is not taken before the last one is through.
// Each due note-off is released before the word that made it due, set by the single head port of the sorted
// cell row (one pop per cycle while the output is not stalled).
// End of stream releases each pending note-off, then one end of track word.
// Reset (rst, synchronous) clears parser, times, pending count and halt flag.
module note_event_stream_to_midi
  import nesm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  output logic        stall_in,
  input  logic        op,
  input  logic [7:0]  data_byte,
  output logic        valid_out,
  input  logic        stall_out,
  output logic [2:0]  kind,
  output logic [27:0] delay_ticks,
  output logic [31:0] delay_vlq,
  output logic [2:0]  delay_vlq_len,
  output logic [7:0]  status_byte,
  output logic [7:0]  first_data,
  output logic [7:0]  second_data,
  output logic [1:0]  error_code,
  output logic        last
);
  state_t state, state_next;
  logic [1:0]  phase;
  logic [7:0]  held_lead, opb0, opb1, cur_b;
  logic        cur_op;
  logic [31:0] read_time, written_time;
  logic        halted;
  logic        full_err;
  logic        released;
  pend_t       head;
  logic [CNT_W-1:0] count;
  cell_ctl_t   ctl;

  nesm_store u_store (.clk(clk), .rst(rst), .ctl(ctl), .head(head), .count(count));

  logic out_free;
  assign out_free = !valid_out || !stall_out;
  assign stall_in = (state != ST_IDLE);

  logic accept;
  assign accept = valid_in && !stall_in;

  // classify the pending word
  logic w_emit, w_is_once, w_loop, w_badlead, w_trunc;
  always_comb begin
    w_emit = 1'b0; w_is_once = 1'b0; w_loop = 1'b0; w_badlead = 1'b0; w_trunc = 1'b0;
    if (cur_op) begin
      w_trunc = (phase != 2'd0);
    end else if (phase == 2'd0) begin
      if (cur_b[7]) begin
        w_loop = (cur_b == 8'hF0);
        w_badlead = (cur_b[7:4] == 4'hB) || (cur_b[7:4] == 4'hC) || (cur_b[7:4] == 4'hD);
      end
    end else if (phase == 2'd2 && held_lead[7:4] != 4'hA) begin
      w_emit = 1'b1;
    end else if (phase == 2'd3) begin
      w_emit = 1'b1;
      w_is_once = 1'b1;
    end
  end

  logic due;
  assign due = (count != '0) && (head.t <= read_time);

  logic [31:0] gap_head, gap_read;
  assign gap_head = (head.t > written_time) ? head.t - written_time : 32'd0;
  assign gap_read = (read_time > written_time) ? read_time - written_time : 32'd0;

  function automatic logic [27:0] clamp(input logic [31:0] v);
    return (v[31:28] != 0) ? DELAY_MAX : v[27:0];
  endfunction

  logic [31:0] dur;
  assign dur = {18'd0, opb1[1:0], cur_b, 4'd0};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && !halted) state_next = ST_FLUSH;
      ST_FLUSH: begin
        if (cur_op && !w_trunc) begin
          if (out_free && !due) state_next = ST_DRAIN;
        end else if (w_trunc || w_badlead) begin
          if (out_free) state_next = ST_IDLE;
        end else if (w_emit || w_loop) begin
          if (out_free && !due) state_next = (w_is_once && full_err) ? ST_ERR : ST_IDLE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ERR: if (out_free) state_next = ST_IDLE;
      ST_DRAIN: if (out_free && count == '0) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic        emit;
  logic [2:0]  e_kind;
  logic [27:0] e_delay;
  logic [7:0]  e_st, e_d1, e_d2;
  logic [1:0]  e_err;
  logic        e_last;

  always_comb begin
    emit = 1'b0; e_kind = KIND_CHAN; e_delay = '0; e_st = '0; e_d1 = '0; e_d2 = '0;
    e_err = ERR_NONE; e_last = 1'b0;
    ctl.cmd = CMD_HOLD;
    ctl.ins.chan = held_lead[3:0];
    ctl.ins.note = opb0[7:1];
    ctl.ins.t = sat_add(sat_add(written_time, gap_read), dur);
    unique case (state)
      ST_FLUSH: begin
        if (w_trunc) begin
          emit = 1'b1; e_kind = KIND_ERR; e_err = ERR_TRUNC; e_last = 1'b1;
        end else if (w_badlead) begin
          emit = 1'b1; e_kind = KIND_ERR; e_err = ERR_LEAD; e_last = 1'b1;
        end else if ((w_emit || w_loop || cur_op) && due) begin
          emit = 1'b1; e_kind = KIND_OFF; e_delay = clamp(gap_head);
          e_st = {4'h8, head.chan}; e_d1 = {1'b0, head.note}; e_d2 = 8'h40;
          ctl.cmd = out_free ? CMD_POP : CMD_HOLD;
        end else if (cur_op) begin
          emit = 1'b0;
        end else if (w_loop) begin
          emit = 1'b1; e_kind = KIND_LOOP; e_delay = clamp(gap_read); e_last = 1'b1;
        end else if (w_emit) begin
          emit = 1'b1; e_kind = KIND_CHAN; e_delay = clamp(gap_read);
          if (w_is_once) begin
            e_st = {4'h9, held_lead[3:0]}; e_d1 = {1'b0, opb0[7:1]};
            e_d2 = {1'b0, opb0[0], opb1[7:2]};
            e_last = !full_err;
            if (out_free && !full_err) ctl.cmd = CMD_INSERT;
          end else begin
            e_st = held_lead; e_d1 = opb0; e_d2 = cur_b; e_last = 1'b1;
          end
        end
      end
      ST_ERR: begin
        emit = 1'b1; e_kind = KIND_ERR; e_err = ERR_FULL; e_last = 1'b1;
      end
      ST_DRAIN: begin
        emit = 1'b1;
        if (count != '0) begin
          e_kind = KIND_OFF; e_delay = released ? 28'd0 : clamp(gap_read);
          e_st = {4'h8, head.chan}; e_d1 = {1'b0, head.note}; e_d2 = 8'h40;
          ctl.cmd = out_free ? CMD_POP : CMD_HOLD;
        end else begin
          e_kind = KIND_END; e_delay = released ? 28'd0 : clamp(gap_read); e_last = 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  assign full_err = (count == CNT_W'(PENDING_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid_out <= 1'b0;
      phase <= 2'd0;
      held_lead <= '0;
      opb0 <= '0;
      opb1 <= '0;
      read_time <= '0;
      written_time <= '0;
      halted <= 1'b0;
      released <= 1'b0;
    end else begin
      state <= state_next;
      if (out_free) valid_out <= emit;
      if (accept) begin
        cur_op <= op;
        cur_b <= data_byte;
      end
      if (emit && out_free) begin
        kind <= e_kind;
        delay_ticks <= e_delay;
        delay_vlq <= vlq(e_delay);
        delay_vlq_len <= vlq_len(e_delay);
        status_byte <= e_st;
        first_data <= e_d1;
        second_data <= e_d2;
        error_code <= e_err;
        last <= e_last;
      end
      if (state == ST_FLUSH) begin
        if (emit && out_free && e_kind == KIND_OFF) begin
          written_time <= (head.t > written_time) ? head.t : written_time;
        end else if (w_trunc || w_badlead) begin
          if (out_free) halted <= 1'b1;
        end else if (cur_op) begin
          // remaining gap is taken by the drain
        end else if (w_emit || w_loop) begin
          if (out_free && !due) begin
            written_time <= sat_add(written_time, gap_read);
            if (w_emit) phase <= 2'd0;
          end
        end else if (phase == 2'd0) begin
          if (!cur_b[7]) begin
            read_time <= sat_add(read_time, cur_b[6] ?
              {19'd0, {1'b0, cur_b[5:0]} + 7'd1, 6'd0} : {24'd0, cur_b});
          end else if (cur_b[7:4] == 4'h8 || cur_b[7:4] == 4'h9 ||
                       cur_b[7:4] == 4'hE || cur_b[7:4] == 4'hA) begin
            held_lead <= cur_b;
            phase <= 2'd1;
          end
        end else if (phase == 2'd1) begin
          opb0 <= cur_b;
          phase <= 2'd2;
        end else begin
          opb1 <= cur_b;
          phase <= 2'd3;
        end
      end
      if (state == ST_ERR && out_free) halted <= 1'b1;
      if (state == ST_DRAIN && out_free) begin
        if (count != '0) begin
          released <= 1'b1;
        end else begin
          released <= 1'b0;
          phase <= 2'd0;
          held_lead <= '0;
          opb0 <= '0;
          opb1 <= '0;
          read_time <= '0;
          written_time <= '0;
        end
      end
    end
  end
endmodule
